@@ design/ptoc_pkg.sv @@
// Shared types and constants for the pre-trade order check.
// Used by the channel interfaces, the configuration registers, the
// multiplier table and the top level. No dependencies.
`default_nettype none

package ptoc_pkg;

  localparam int NUM_INSTRUMENTS = 256;
  localparam int TABLE_AW        = $clog2(NUM_INSTRUMENTS);

  localparam int INSTR_W      = 8;
  localparam int PRICE_W      = 32;
  localparam int VOL_W        = 32;
  localparam int MULT_W       = 16;
  localparam int VCAP_W       = 31;
  localparam int DEV_W        = 16;
  localparam int NOTIONAL_W   = 63;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 63;

  // Deviation test operands: |price - ref| scaled by 2^16 against dev * ref.
  localparam int DEV_SHIFT    = 16;
  localparam int DEVPROD_W    = DEV_W + PRICE_W;
  // price * volume, and its split for the multiplier product.
  localparam int PV_W         = PRICE_W + VCAP_W;
  localparam int PVLO_W       = 32;
  localparam int PVHI_W       = PV_W - PVLO_W;
  localparam int PLO_W        = PVLO_W + MULT_W;
  localparam int PHI_W        = PVHI_W + MULT_W;
  localparam int NOTPROD_W    = PV_W + MULT_W;

  localparam logic [MULT_W-1:0] MULT_ONE = MULT_W'(1);

  localparam logic CMD_CHECK    = 1'b0;
  localparam logic CMD_SET_MULT = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HALTED,
    CFG_MAX_VOLUME,
    CFG_MAX_DEVIATION,
    CFG_MAX_NOTIONAL
  } cfg_index_t;

  typedef enum logic [2:0] {
    RSN_OK,
    RSN_HALTED,
    RSN_VOL_NONPOS,
    RSN_VOL_CAP,
    RSN_DEVIATION,
    RSN_NOTIONAL
  } reason_t;

  typedef struct packed {
    logic                  halted;
    logic [VCAP_W-1:0]     max_order_volume;
    logic [DEV_W-1:0]      max_price_deviation;
    logic [NOTIONAL_W-1:0] max_notional;
  } cfg_t;

  typedef struct packed {
    logic                en;
    logic [TABLE_AW-1:0] addr;
    logic [MULT_W-1:0]   data;
  } tbl_wr_t;

  typedef struct packed {
    logic                en;
    logic [TABLE_AW-1:0] addr;
  } tbl_rd_t;

endpackage

`default_nettype wire

@@ design/ptoc_ifs.sv @@
// Request and result channel interfaces of the pre-trade order check.
// Depends on ptoc_pkg for field widths and the reason codes.
`default_nettype none

interface ptoc_req_if import ptoc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [INSTR_W-1:0]        instrument;
  logic [PRICE_W-1:0]        limit_price;
  logic [PRICE_W-1:0]        ref_price;
  logic signed [VOL_W-1:0]   volume;
  logic [MULT_W-1:0]         multiplier_value;

  modport source (output valid, cmd, instrument, limit_price, ref_price, volume,
                  multiplier_value, input ready);
  modport sink   (input valid, cmd, instrument, limit_price, ref_price, volume,
                  multiplier_value, output ready);
endinterface

interface ptoc_res_if import ptoc_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    pass;
  reason_t reason;

  modport source (output valid, pass, reason, input ready);
  modport sink   (input valid, pass, reason, output ready);
endinterface

`default_nettype wire

@@ design/pre_trade_order_check_core.sv @@
// Pre-trade order check: four-stage pipeline around the multiplier table.
// Each request passes stages 1 to 3 and the output register; one request
// is taken every cycle, each stage holding only while its successor holds.
// Table writes land at acceptance, so a later check always sees them.
// Reset (synchronous) empties the pipeline, zeroes the config registers and
// clears the table's valid bits, so every multiplier reads one; no clearing pass.
`default_nettype none

module pre_trade_order_check_core import ptoc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  ptoc_req_if.sink                    req,
  ptoc_res_if.source                  res,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t              cfg;
  tbl_wr_t           tbl_wr;
  tbl_rd_t           tbl_rd;
  logic [MULT_W-1:0] tbl_rd_data;

  ptoc_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  ptoc_mult_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (tbl_wr),
    .rd      (tbl_rd),
    .rd_data (tbl_rd_data)
  );

  // Elastic flow control: a stage may load when it is empty or draining.
  logic v1, v2, v3;
  logic ready1, ready2, ready3, ready_o;
  logic accept;

  assign ready_o   = !res.valid || res.ready;
  assign ready3    = !v3 || ready_o;
  assign ready2    = !v2 || ready3;
  assign ready1    = !v1 || ready2;
  assign req.ready = ready1;
  assign accept    = req.valid && ready1;

  logic in_range;
  assign in_range = (32'(req.instrument) < NUM_INSTRUMENTS);

  always_comb begin
    tbl_wr.en   = accept && (req.cmd == CMD_SET_MULT) && in_range;
    tbl_wr.addr = req.instrument[TABLE_AW-1:0];
    tbl_wr.data = (req.multiplier_value == '0) ? MULT_ONE : req.multiplier_value;
    tbl_rd.en   = ready1;
    tbl_rd.addr = req.instrument[TABLE_AW-1:0];
  end

  // Stage 1: request registers; the table word arrives alongside.
  logic               s1_cmd;
  logic               s1_in_range;
  logic [PRICE_W-1:0] s1_price;
  logic [PRICE_W-1:0] s1_ref;
  logic [VOL_W-1:0]   s1_vol;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      s1_cmd      <= req.cmd;
      s1_in_range <= in_range;
      s1_price    <= req.limit_price;
      s1_ref      <= req.ref_price;
      s1_vol      <= req.volume;
    end
  end

  reason_t              early1;
  logic [MULT_W-1:0]    mult1;
  logic [PRICE_W-1:0]   diff1;
  logic                 dev_on1;
  logic                 not_on1;
  logic [DEVPROD_W-1:0] devref1;
  logic [PV_W-1:0]      pv1;

  always_comb begin
    if (cfg.halted) begin
      early1 = RSN_HALTED;
    end else if (s1_vol[VOL_W-1] || (s1_vol == '0)) begin
      early1 = RSN_VOL_NONPOS;
    end else if ((cfg.max_order_volume != '0) &&
                 (s1_vol[VCAP_W-1:0] > cfg.max_order_volume)) begin
      early1 = RSN_VOL_CAP;
    end else begin
      early1 = RSN_OK;
    end
  end

  assign mult1   = s1_in_range ? tbl_rd_data : MULT_ONE;
  assign diff1   = (s1_price > s1_ref) ? (s1_price - s1_ref) : (s1_ref - s1_price);
  assign dev_on1 = (cfg.max_price_deviation != '0) && (s1_ref != '0) && (s1_price != '0);
  assign not_on1 = (cfg.max_notional != '0) && (s1_price != '0);
  assign devref1 = cfg.max_price_deviation * s1_ref;
  // Volume is known positive whenever this product matters.
  assign pv1     = s1_price * s1_vol[VCAP_W-1:0];

  // Stage 2: deviation compare and the split notional multiply.
  logic                 s2_cmd;
  reason_t              s2_early;
  logic                 s2_dev_on;
  logic                 s2_not_on;
  logic [PRICE_W-1:0]   s2_diff;
  logic [DEVPROD_W-1:0] s2_devref;
  logic [PV_W-1:0]      s2_pv;
  logic [MULT_W-1:0]    s2_mult;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      s2_cmd    <= s1_cmd;
      s2_early  <= early1;
      s2_dev_on <= dev_on1;
      s2_not_on <= not_on1;
      s2_diff   <= diff1;
      s2_devref <= devref1;
      s2_pv     <= pv1;
      s2_mult   <= mult1;
    end
  end

  logic             dev_fail2;
  reason_t          reason2;
  logic [PLO_W-1:0] plo2;
  logic [PHI_W-1:0] phi2;

  assign dev_fail2 = s2_dev_on && ({s2_diff, DEV_SHIFT'(0)} > s2_devref);
  assign reason2   = (s2_early != RSN_OK) ? s2_early :
                     dev_fail2            ? RSN_DEVIATION : RSN_OK;
  assign plo2      = s2_pv[PVLO_W-1:0] * s2_mult;
  assign phi2      = s2_pv[PV_W-1:PVLO_W] * s2_mult;

  // Stage 3: recombine the notional product and make the final decision.
  logic             s3_cmd;
  reason_t          s3_reason;
  logic             s3_not_on;
  logic [PLO_W-1:0] s3_plo;
  logic [PHI_W-1:0] s3_phi;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      s3_cmd    <= s2_cmd;
      s3_reason <= reason2;
      s3_not_on <= s2_not_on;
      s3_plo    <= plo2;
      s3_phi    <= phi2;
    end
  end

  logic [NOTPROD_W-1:0] notional3;
  logic                 not_fail3;
  reason_t              final3;

  assign notional3 = {s3_phi, PVLO_W'(0)} + NOTPROD_W'(s3_plo);
  assign not_fail3 = s3_not_on && (notional3 > NOTPROD_W'(cfg.max_notional));

  always_comb begin
    if (s3_cmd == CMD_SET_MULT) begin
      final3 = RSN_OK;
    end else if (s3_reason != RSN_OK) begin
      final3 = s3_reason;
    end else if (not_fail3) begin
      final3 = RSN_NOTIONAL;
    end else begin
      final3 = RSN_OK;
    end
  end

  // Output register, and the reason of the most recent blocked order.
  reason_t last_block_reason;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (ready_o) begin
      res.valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o) begin
      res.pass   <= (final3 == RSN_OK);
      res.reason <= final3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_block_reason <= RSN_OK;
    end else if (ready_o && v3 && (final3 != RSN_OK)) begin
      last_block_reason <= final3;
    end
  end

  a_pass_matches_reason: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.pass == (res.reason == RSN_OK)))
    else $error("pass flag disagrees with reason code");

  a_last_block_tracks: assert property (@(posedge clk) disable iff (rst)
    (ready_o && v3 && (final3 != RSN_OK)) |=> (last_block_reason == res.reason))
    else $error("last block reason not updated with blocked result");

  a_set_mult_passes: assert property (@(posedge clk) disable iff (rst)
    (ready_o && v3 && (s3_cmd == CMD_SET_MULT)) |=> (res.valid && res.pass))
    else $error("multiplier write did not give a passing result");

  a_accept_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready && !(v1 && v2 && v3)) |-> req.ready)
    else $error("request refused while the pipeline has a free stage");

endmodule

`default_nettype wire

@@ design/ptoc_cfg_regs.sv @@
// Configuration registers of the pre-trade order check.
// Depends on ptoc_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module ptoc_cfg_regs import ptoc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   wr_en,
  input  wire logic [CFG_INDEX_W-1:0] index,
  input  wire logic [CFG_DATA_W-1:0]  wdata,
  output cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (cfg_index_t'(index))
        CFG_HALTED:        cfg.halted              <= wdata[0];
        CFG_MAX_VOLUME:    cfg.max_order_volume    <= wdata[VCAP_W-1:0];
        CFG_MAX_DEVIATION: cfg.max_price_deviation <= wdata[DEV_W-1:0];
        CFG_MAX_NOTIONAL:  cfg.max_notional        <= wdata[NOTIONAL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/ptoc_mult_table.sv @@
// Contract multiplier table: one synchronous memory with a registered read.
// Valid bits per entry make an unwritten entry read as one after reset.
// Depends on ptoc_pkg for the table size and port bundles.
`default_nettype none

module ptoc_mult_table import ptoc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tbl_wr_t           wr,
  input  wire tbl_rd_t           rd,
  output logic [MULT_W-1:0]      rd_data
);

  logic [MULT_W-1:0]          mem [NUM_INSTRUMENTS];
  logic [NUM_INSTRUMENTS-1:0] written;
  logic [MULT_W-1:0]          rd_word;
  logic                       rd_written;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_word <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_written <= written[rd.addr];
    end
  end

  assign rd_data = rd_written ? rd_word : MULT_ONE;

endmodule

`default_nettype wire
